FILE: rtl/pcbb_pkg.sv
// Shared types and constants of the prefix-compressed block builder.
`default_nettype none
package pcbb_pkg;

   localparam int MAX_KEY_LEN    = 32;
   localparam int MAX_RESTARTS   = 32;
   localparam int KEY_IDX_W      = $clog2(MAX_KEY_LEN);
   localparam int KEY_LEN_W      = 6;
   localparam int RST_IDX_W      = $clog2(MAX_RESTARTS);
   localparam int RST_CNT_W      = 6;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = QUEUE_PTR_W + 1;
   localparam logic [7:0] INTERVAL_RESET = 8'd16;

   typedef enum logic [1:0] {
      CMD_BEGIN  = 2'd0,
      CMD_KEY    = 2'd1,
      CMD_VALUE  = 2'd2,
      CMD_FINISH = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                kind;
      logic [KEY_LEN_W-1:0]   key_len;
      logic [15:0]            value_len;
      logic [7:0]             data_byte;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_EMIT,
      ST_TRAILER
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/pcbb_front.sv
// Front end: classifies requests, saturates key lengths and queues them.
`default_nettype none
module pcbb_front
   import pcbb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,
   output logic             item_valid,
   output item_type         item,
   input  wire logic        item_pop
);

   item_type                queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   item_type                decoded;
   logic                    push;
   logic                    pop;

   always_comb begin
      decoded.kind      = cmd_type'(req_tdata[1:0]);
      decoded.value_len = req_tdata[23:8];
      decoded.data_byte = req_tdata[31:24];
      if (req_tdata[7:2] > KEY_LEN_W'(MAX_KEY_LEN)) begin
         decoded.key_len = KEY_LEN_W'(MAX_KEY_LEN);
      end else begin
         decoded.key_len = req_tdata[7:2];
      end
   end

   assign req_tready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != '0);
   assign pop        = item_pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/pcbb_back.sv
// Back end: key compare, header and key emission, value pass-through and trailer.
`default_nettype none
module pcbb_back
   import pcbb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   input  wire logic        item_valid,
   input  item_type         item,
   output logic             item_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   state_type              state_ff, state_in;
   logic [7:0]             interval_ff;
   logic [7:0]             bank0_ff [MAX_KEY_LEN];
   logic [7:0]             bank1_ff [MAX_KEY_LEN];
   logic [31:0]            offs_ff  [MAX_RESTARTS];
   logic                   sel_ff, sel_in;
   logic [KEY_LEN_W-1:0]   prev_len_ff, prev_len_in;
   logic [KEY_LEN_W-1:0]   cnt_ff, cnt_in;
   logic [KEY_LEN_W-1:0]   pend_ff, pend_in;
   logic [15:0]            vrem_ff, vrem_in;
   logic                   acc_ff, acc_in;
   logic [7:0]             esr_ff, esr_in;
   logic [RST_CNT_W-1:0]   rc_ff, rc_in;
   logic [31:0]            bo_ff, bo_in;
   logic [KEY_LEN_W-1:0]   idx_ff, idx_in;
   logic [KEY_LEN_W-1:0]   kidx_ff, kidx_in;
   logic [KEY_LEN_W-1:0]   pos_ff, pos_in;
   logic [KEY_LEN_W-1:0]   total_ff, total_in;
   logic [2:0]             hlen_ff, hlen_in;
   logic [39:0]            hdr_ff, hdr_in;
   logic [31:0]            pack_ff, pack_in;
   logic [1:0]             fill_ff, fill_in;
   logic [RST_CNT_W-1:0]   tidx_ff, tidx_in;

   logic                   out_valid_ff, out_valid_in;
   logic [31:0]            out_data_ff, out_data_in;
   logic [2:0]             out_nb_ff, out_nb_in;
   logic                   out_drop_ff, out_drop_in;
   logic                   out_last_ff, out_last_in;

   logic                   slot_free;
   logic                   key_we;
   logic                   off_we;
   logic [KEY_IDX_W-1:0]   rd_idx;
   logic [7:0]             prev_byte;
   logic [7:0]             inc_byte;
   logic [KEY_LEN_W-1:0]   lim;
   logic                   greater;
   logic                   match_step;
   logic [7:0]             interval;
   logic                   do_restart;
   logic [KEY_LEN_W-1:0]   shared;
   logic [KEY_LEN_W-1:0]   unshared;
   logic [7:0]             emit_byte;
   logic [31:0]            word;
   logic                   final_byte;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign rd_idx    = (state_ff == ST_EMIT) ? kidx_ff[KEY_IDX_W-1:0] : idx_ff[KEY_IDX_W-1:0];
   assign prev_byte = sel_ff ? bank1_ff[rd_idx] : bank0_ff[rd_idx];
   assign inc_byte  = sel_ff ? bank0_ff[rd_idx] : bank1_ff[rd_idx];
   assign lim       = (cnt_ff < prev_len_ff) ? cnt_ff : prev_len_ff;
   assign match_step = (idx_ff < lim) && (inc_byte == prev_byte);
   assign greater   = (idx_ff < lim) ? (inc_byte > prev_byte) : (cnt_ff > prev_len_ff);
   assign interval  = (interval_ff == 8'd0) ? 8'd1 : interval_ff;
   assign do_restart = (esr_ff >= interval) && (rc_ff < RST_CNT_W'(MAX_RESTARTS));
   assign shared    = do_restart ? '0 : idx_ff;
   assign unshared  = cnt_ff - shared;
   assign emit_byte = (pos_ff < KEY_LEN_W'(hlen_ff)) ? hdr_ff[7:0] : prev_byte;
   assign word      = pack_ff | (32'(emit_byte) << {fill_ff, 3'b000});
   assign final_byte = (pos_ff == total_ff - 1'b1);

   always_comb begin
      state_in = state_ff;
      if (slot_free) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  unique case (item.kind)
                     CMD_BEGIN: begin
                        if (item.key_len == '0) begin
                           state_in = ST_COMPARE;
                        end
                     end
                     CMD_KEY: begin
                        if (cnt_ff < pend_ff && cnt_ff + 1'b1 == pend_ff) begin
                           state_in = ST_COMPARE;
                        end
                     end
                     CMD_VALUE: state_in = ST_IDLE;
                     CMD_FINISH: state_in = ST_TRAILER;
                     default: state_in = ST_IDLE;
                  endcase
               end
            end
            ST_COMPARE: begin
               if (!match_step) begin
                  state_in = greater ? ST_EMIT : ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (final_byte) begin
                  state_in = ST_IDLE;
               end
            end
            ST_TRAILER: begin
               if (tidx_ff >= rc_ff) begin
                  state_in = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_comb begin
      item_pop     = 1'b0;
      key_we       = 1'b0;
      off_we       = 1'b0;
      sel_in       = sel_ff;
      prev_len_in  = prev_len_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      vrem_in      = vrem_ff;
      acc_in       = acc_ff;
      esr_in       = esr_ff;
      rc_in        = rc_ff;
      bo_in        = bo_ff;
      idx_in       = idx_ff;
      kidx_in      = kidx_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      hlen_in      = hlen_ff;
      hdr_in       = hdr_ff;
      pack_in      = pack_ff;
      fill_in      = fill_ff;
      tidx_in      = tidx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_nb_in    = out_nb_ff;
      out_drop_in  = out_drop_ff;
      out_last_in  = out_last_ff;
      if (slot_free) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  item_pop = 1'b1;
                  unique case (item.kind)
                     CMD_BEGIN: begin
                        pend_in = item.key_len;
                        vrem_in = item.value_len;
                        cnt_in  = '0;
                        acc_in  = 1'b0;
                        idx_in  = '0;
                     end
                     CMD_KEY: begin
                        if (cnt_ff < pend_ff) begin
                           key_we = 1'b1;
                           cnt_in = cnt_ff + 1'b1;
                           idx_in = '0;
                        end
                     end
                     CMD_VALUE: begin
                        if (cnt_ff == pend_ff && vrem_ff != 16'd0) begin
                           vrem_in = vrem_ff - 1'b1;
                           if (acc_ff) begin
                              bo_in        = bo_ff + 1'b1;
                              out_valid_in = 1'b1;
                              out_data_in  = 32'(item.data_byte);
                              out_nb_in    = 3'd1;
                              out_drop_in  = 1'b0;
                              out_last_in  = 1'b1;
                           end
                        end
                     end
                     CMD_FINISH: tidx_in = '0;
                     default: tidx_in = tidx_ff;
                  endcase
               end
            end
            ST_COMPARE: begin
               if (match_step) begin
                  idx_in = idx_ff + 1'b1;
               end else if (!greater) begin
                  acc_in       = 1'b0;
                  out_valid_in = 1'b1;
                  out_data_in  = '0;
                  out_nb_in    = 3'd0;
                  out_drop_in  = 1'b1;
                  out_last_in  = 1'b1;
               end else begin
                  off_we = do_restart;
                  if (do_restart) begin
                     rc_in = rc_ff + 1'b1;
                  end
                  esr_in      = ((esr_ff >= interval) ? 8'd0 : esr_ff) + 8'd1;
                  sel_in      = !sel_ff;
                  prev_len_in = cnt_ff;
                  acc_in      = 1'b1;
                  kidx_in     = shared;
                  pos_in      = '0;
                  pack_in     = '0;
                  fill_in     = '0;
                  if (vrem_ff < 16'd128) begin
                     hlen_in = 3'd3;
                     hdr_in  = {16'd0, vrem_ff[7:0], 2'b00, unshared, 2'b00, shared};
                  end else if (vrem_ff < 16'd16384) begin
                     hlen_in = 3'd4;
                     hdr_in  = {8'd0, 1'b0, vrem_ff[13:7], 1'b1, vrem_ff[6:0],
                                2'b00, unshared, 2'b00, shared};
                  end else begin
                     hlen_in = 3'd5;
                     hdr_in  = {6'd0, vrem_ff[15:14], 1'b1, vrem_ff[13:7], 1'b1,
                                vrem_ff[6:0], 2'b00, unshared, 2'b00, shared};
                  end
                  total_in = unshared + KEY_LEN_W'(hlen_in);
               end
            end
            ST_EMIT: begin
               pos_in = pos_ff + 1'b1;
               bo_in  = bo_ff + 1'b1;
               if (pos_ff < KEY_LEN_W'(hlen_ff)) begin
                  hdr_in = hdr_ff >> 8;
               end else begin
                  kidx_in = kidx_ff + 1'b1;
               end
               if (fill_ff == 2'd3 || final_byte) begin
                  out_valid_in = 1'b1;
                  out_data_in  = word;
                  out_nb_in    = {1'b0, fill_ff} + 3'd1;
                  out_drop_in  = 1'b0;
                  out_last_in  = final_byte;
                  pack_in      = '0;
                  fill_in      = '0;
               end else begin
                  pack_in = word;
                  fill_in = fill_ff + 1'b1;
               end
            end
            ST_TRAILER: begin
               out_valid_in = 1'b1;
               out_nb_in    = 3'd4;
               out_drop_in  = 1'b0;
               if (tidx_ff < rc_ff) begin
                  // The first restart point is always offset zero.
                  out_data_in = (tidx_ff == '0) ? 32'd0 : offs_ff[tidx_ff[RST_IDX_W-1:0]];
                  out_last_in = 1'b0;
                  tidx_in     = tidx_ff + 1'b1;
               end else begin
                  out_data_in = 32'(rc_ff);
                  out_last_in = 1'b1;
                  prev_len_in = '0;
                  cnt_in      = '0;
                  pend_in     = '0;
                  vrem_in     = '0;
                  acc_in      = 1'b0;
                  esr_in      = '0;
                  rc_in       = RST_CNT_W'(1);
                  bo_in       = '0;
               end
            end
            default: item_pop = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= INTERVAL_RESET;
         sel_ff       <= 1'b0;
         prev_len_ff  <= '0;
         cnt_ff       <= '0;
         pend_ff      <= '0;
         vrem_ff      <= '0;
         acc_ff       <= 1'b0;
         esr_ff       <= '0;
         rc_ff        <= RST_CNT_W'(1);
         bo_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
         sel_ff       <= sel_in;
         prev_len_ff  <= prev_len_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         vrem_ff      <= vrem_in;
         acc_ff       <= acc_in;
         esr_ff       <= esr_in;
         rc_ff        <= rc_in;
         bo_ff        <= bo_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      kidx_ff     <= kidx_in;
      pos_ff      <= pos_in;
      total_ff    <= total_in;
      hlen_ff     <= hlen_in;
      hdr_ff      <= hdr_in;
      pack_ff     <= pack_in;
      fill_ff     <= fill_in;
      tidx_ff     <= tidx_in;
      out_data_ff <= out_data_in;
      out_nb_ff   <= out_nb_in;
      out_drop_ff <= out_drop_in;
      out_last_ff <= out_last_in;
      if (key_we) begin
         if (sel_ff) begin
            bank0_ff[cnt_ff[KEY_IDX_W-1:0]] <= item.data_byte;
         end else begin
            bank1_ff[cnt_ff[KEY_IDX_W-1:0]] <= item.data_byte;
         end
      end
      if (off_we) begin
         offs_ff[rc_ff[RST_IDX_W-1:0]] <= bo_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_nb_ff, out_data_ff};
   assign rsp_tuser  = out_drop_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

FILE: rtl/prefix_compressed_block_builder.sv
// Top level of the prefix-compressed block builder.
// A request is queued and executed by the back end one at a time.
// Begin, value and stray requests are handled in the idle state; a completing key byte moves
// to compare, which walks the shared prefix, then to emit for header and unshared key bytes.
// Finish sends the restart offsets, then their count. The output register stalls the back end.
// Reset is synchronous: queue and control registers clear, the restart interval returns to 16.
`default_nettype none
module prefix_compressed_block_builder
   import pcbb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // command, key_len, value_len, data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // out_data, out_nbytes, zero fill
   output logic             rsp_tuser,   // entry_dropped
   output logic             rsp_tlast
);

   logic     item_valid;
   item_type item;
   logic     item_pop;

   pcbb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   pcbb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire
